/* hw/rtl/mnrs_pkg.sv */
// Package with the shared types, constants and register codes of the note repeat scheduler.
`default_nettype none
package mnrs_pkg;

  localparam int MAX_REPEATS_DEF       = 32;
  localparam int RING_DEPTH_DEF        = 1024;
  localparam int MAX_BLOCK_SAMPLES_DEF = 4096;

  localparam int CFG_DATA_W  = 20;
  localparam int CFG_INDEX_W = 3;

  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REPEAT_COUNT  = 3'd0,
    CFG_NOTE_LENGTH   = 3'd1,
    CFG_GATE_FRACTION = 3'd2,
    CFG_PITCH_STEP    = 3'd3,
    CFG_SKEW          = 3'd4,
    CFG_BLOCK_SAMPLES = 3'd5,
    CFG_RING_BLOCKS   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] numer;
    logic [DIV_DEN_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/mnrs_req_if.sv */
// Input channel interface carrying one request word.
`default_nettype none
interface mnrs_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  status_byte;
  logic [6:0]  data_first;
  logic [6:0]  data_second;
  logic [11:0] sample_position;

  modport source (output valid, req_type, status_byte, data_first, data_second,
                  sample_position, input ready);
  modport sink (input valid, req_type, status_byte, data_first, data_second,
                sample_position, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mnrs_rsp_if.sv */
// Output channel interface carrying one scheduled event word.
`default_nettype none
interface mnrs_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_status;
  logic [6:0]  out_data_first;
  logic [6:0]  out_data_second;
  logic [9:0]  target_block;
  logic [11:0] block_position;
  logic        last_of_run;

  modport source (output valid, out_status, out_data_first, out_data_second,
                  target_block, block_position, last_of_run, input ready);
  modport sink (input valid, out_status, out_data_first, out_data_second,
                target_block, block_position, last_of_run, output ready);
endinterface
`default_nettype wire

/* hw/rtl/mnrs_divider.sv */
// Shared restoring divider that yields one quotient bit per cycle.
`default_nettype none
module mnrs_divider import mnrs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] acc;
  logic [DIV_NUM_W-1:0] quo;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  always_comb begin
    shifted = {acc, quo[DIV_NUM_W-1]};
    diff    = shifted - {1'b0, den};
    ge      = shifted >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        acc  <= '0;
        quo  <= req.numer;
        den  <= req.denom;
      end else if (busy) begin
        acc <= ge ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
        quo <= {quo[DIV_NUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{busy: busy, done: done, quot: quo, rem: acc};

endmodule
`default_nettype wire

/* hw/rtl/midi_note_repeat_scheduler_core.sv */
// Top level of the MIDI note repeat scheduler: sequencer, registers and output word register.
// A pass-through word goes through the emit state to the output word register, and the input is
// ready again once it is loaded; a tick is dropped in pass-through mode and otherwise advances the
// current block modulo the ring size via the divider. A note-on with repeats holds the input while
// the shared divider places each step and each event in the ring; output stalls add to it.
// Reset loads the register defaults and clears the current block and all handshakes.
`default_nettype none
module midi_note_repeat_scheduler_core import mnrs_pkg::*; #(
  parameter int MAX_REPEATS       = MAX_REPEATS_DEF,
  parameter int RING_DEPTH        = RING_DEPTH_DEF,
  parameter int MAX_BLOCK_SAMPLES = MAX_BLOCK_SAMPLES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  mnrs_req_if.sink                    req,
  mnrs_rsp_if.source                  rsp,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CUR_W = $clog2(RING_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_N3, ST_SK, ST_SP, ST_SN, ST_SWAIT, ST_SDONE, ST_MUL, ST_SUM,
    ST_OFF, ST_PL, ST_PLW1, ST_PLW2, ST_EMIT, ST_TICKW
  } state_t;

  logic [5:0]  repeat_count;
  logic [19:0] note_length_samples;
  logic [15:0] gate_fraction;
  logic [7:0]  pitch_step;
  logic [15:0] skew;
  logic [12:0] block_samples;
  logic [10:0] ring_blocks;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count        <= 6'd1;
      note_length_samples <= 20'd24000;
      gate_fraction       <= 16'd65535;
      pitch_step          <= 8'd0;
      skew                <= 16'd0;
      block_samples       <= 13'd512;
      ring_blocks         <= 11'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REPEAT_COUNT:  repeat_count        <= cfg_data[5:0];
        CFG_NOTE_LENGTH:   note_length_samples <= cfg_data[19:0];
        CFG_GATE_FRACTION: gate_fraction       <= cfg_data[15:0];
        CFG_PITCH_STEP:    pitch_step          <= cfg_data[7:0];
        CFG_SKEW:          skew                <= cfg_data[15:0];
        CFG_BLOCK_SAMPLES: block_samples       <= cfg_data[12:0];
        CFG_RING_BLOCKS:   ring_blocks         <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  logic [5:0]           n_eff;
  logic [DIV_DEN_W-1:0] b_eff;
  logic [12:0]          ring_eff;
  logic                 skew_neg;
  logic                 skew_zero;
  logic [15:0]          skew_abs;

  always_comb begin
    if (repeat_count == 6'd0) n_eff = 6'd1;
    else if (repeat_count > 6'(MAX_REPEATS)) n_eff = 6'(MAX_REPEATS);
    else n_eff = repeat_count;
    if (block_samples == 13'd0) b_eff = DIV_DEN_W'(1);
    else if (DIV_DEN_W'(block_samples) > DIV_DEN_W'(MAX_BLOCK_SAMPLES))
      b_eff = DIV_DEN_W'(MAX_BLOCK_SAMPLES);
    else b_eff = DIV_DEN_W'(block_samples);
    if (ring_blocks == 11'd0) ring_eff = 13'd1;
    else if (13'(ring_blocks) > 13'(RING_DEPTH)) ring_eff = 13'(RING_DEPTH);
    else ring_eff = 13'(ring_blocks);
    skew_neg  = skew[15];
    skew_zero = skew == 16'd0;
    skew_abs  = skew_neg ? 16'(-skew) : skew;
  end

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_numer;
  logic [DIV_DEN_W-1:0] div_denom;

  assign div_req = '{start: div_start, numer: div_numer, denom: div_denom};

  mnrs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  state_t state;
  logic [CUR_W-1:0]   cur;
  logic [DIV_NUM_W-1:0] cur_ext;
  logic               pass;
  logic               kind_off;
  logic               zmode;
  logic [5:0]         j;
  logic [5:0]         kk;
  logic [10:0]        n2;
  logic [15:0]        n3;
  logic [10:0]        k2;
  logic [15:0]        kn2;
  logic signed [17:0] poly;
  logic signed [17:0] s_new;
  logic signed [17:0] s0;
  logic signed [17:0] s1;
  logic signed [38:0] prod_on;
  logic signed [39:0] prod_d;
  logic signed [56:0] prod_g;
  logic signed [25:0] on_t;
  logic signed [25:0] off_t;
  logic [11:0]        pos;
  logic [7:0]         msg_st;
  logic [6:0]         msg_d1;
  logic [6:0]         msg_d2;
  logic [6:0]         note;
  logic [9:0]         ev_tb;
  logic [11:0]        ev_pos;

  logic               out_v;
  logic [7:0]         out_st;
  logic [6:0]         out_d1;
  logic [6:0]         out_d2;
  logic [9:0]         out_tb;
  logic [11:0]        out_pos;
  logic               out_last;

  logic [5:0]          k_sel;
  logic signed [36:0]  num;
  logic signed [9:0]   nsum;
  logic signed [38:0]  on_adj;
  logic signed [38:0]  on_q;
  logic signed [56:0]  off_adj;
  logic signed [56:0]  off_q;
  logic signed [25:0]  ev_dist;
  logic                take;

  always_comb begin
    cur_ext = DIV_NUM_W'(cur);
    k_sel   = skew_neg ? n_eff - j : j;
    num     = $signed({5'd0, kn2, 16'd0}) + $signed({1'b0, skew_abs, 1'b0}) * poly;
    nsum    = $signed({3'd0, note}) + $signed({{2{pitch_step[7]}}, pitch_step});
    on_adj  = prod_on + (prod_on[38] ? 39'sd65535 : 39'sd0);
    on_q    = on_adj >>> 16;
    off_adj = prod_g + (prod_g[56] ? 57'sd4294967295 : 57'sd0);
    off_q   = off_adj >>> 32;
    ev_dist = kind_off ? off_t : on_t;
    take    = !out_v || rsp.ready;
  end

  assign req.ready = state == ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= '0;
      div_start <= 1'b0;
      out_v     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_v && rsp.ready && state != ST_EMIT) out_v <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            pos    <= req.sample_position;
            msg_st <= req.status_byte;
            msg_d1 <= req.data_first;
            msg_d2 <= req.data_second;
            note   <= req.data_first;
            n2     <= 11'(n_eff * n_eff);
            j      <= '0;
            kind_off <= 1'b0;
            if (n_eff == 6'd1) begin
              if (!req.req_type) begin
                pass   <= 1'b1;
                ev_tb  <= cur_ext[9:0];
                ev_pos <= req.sample_position;
                state  <= ST_EMIT;
              end
            end else if (req.req_type) begin
              div_numer <= cur_ext + 1'b1;
              div_denom <= DIV_DEN_W'(ring_eff);
              div_start <= 1'b1;
              state     <= ST_TICKW;
            end else if (req.status_byte[7:4] == STAT_NOTE_ON &&
                         req.data_second != 7'd0) begin
              pass  <= 1'b0;
              state <= ST_N3;
            end
          end
        end
        ST_N3: begin
          n3    <= 16'(n2 * n_eff);
          state <= ST_SK;
        end
        ST_SK: begin
          if (j >= n_eff) begin
            s_new <= 18'sd65536;
            state <= ST_SDONE;
          end else if (skew_zero) begin
            div_numer <= DIV_NUM_W'({j, 16'd0});
            div_denom <= DIV_DEN_W'(n_eff);
            div_start <= 1'b1;
            zmode     <= 1'b1;
            state     <= ST_SWAIT;
          end else begin
            kk    <= k_sel;
            k2    <= 11'(k_sel * k_sel);
            kn2   <= 16'(k_sel * n2);
            state <= ST_SP;
          end
        end
        ST_SP: begin
          poly  <= $signed({2'd0, 16'(k2 * kk)}) + $signed({7'd0, k2})
                   - $signed({2'd0, kn2});
          state <= ST_SN;
        end
        ST_SN: begin
          div_numer <= num[36] ? '0 : num[DIV_NUM_W-1:0];
          div_denom <= DIV_DEN_W'(n3);
          div_start <= 1'b1;
          zmode     <= 1'b0;
          state     <= ST_SWAIT;
        end
        ST_SWAIT: begin
          if (div_rsp.done) begin
            if (zmode || !skew_neg) s_new <= $signed({1'b0, div_rsp.quot[16:0]});
            else s_new <= 18'sd65536 - $signed({1'b0, div_rsp.quot[16:0]});
            state <= ST_SDONE;
          end
        end
        ST_SDONE: begin
          if (j == 6'd0) begin
            s0    <= s_new;
            j     <= 6'd1;
            state <= ST_SK;
          end else begin
            s1    <= s_new;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (nsum < 0) note <= 7'd0;
          else if (nsum > 10'sd127) note <= 7'd127;
          else note <= nsum[6:0];
          prod_on <= s0 * $signed({1'b0, note_length_samples});
          prod_d  <= 40'(19'(s1) - 19'(s0)) * $signed({1'b0, note_length_samples});
          state   <= ST_SUM;
        end
        ST_SUM: begin
          on_t   <= $signed({14'd0, pos}) + on_q[25:0];
          prod_g <= prod_d * $signed({1'b0, gate_fraction});
          state  <= ST_OFF;
        end
        ST_OFF: begin
          off_t    <= on_t + off_q[25:0] - 26'sd1;
          kind_off <= 1'b0;
          state    <= ST_PL;
        end
        ST_PL: begin
          div_numer <= ev_dist[25] ? '0 : DIV_NUM_W'(ev_dist[24:0]);
          div_denom <= b_eff;
          div_start <= 1'b1;
          state     <= ST_PLW1;
        end
        ST_PLW1: begin
          if (div_rsp.done) begin
            ev_pos    <= div_rsp.rem[11:0];
            div_numer <= cur_ext + div_rsp.quot;
            div_denom <= DIV_DEN_W'(ring_eff);
            div_start <= 1'b1;
            state     <= ST_PLW2;
          end
        end
        ST_PLW2: begin
          if (div_rsp.done) begin
            ev_tb <= div_rsp.rem[9:0];
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (take) begin
            out_v   <= 1'b1;
            out_tb  <= ev_tb;
            out_pos <= ev_pos;
            if (pass) begin
              out_st   <= msg_st;
              out_d1   <= msg_d1;
              out_d2   <= msg_d2;
              out_last <= 1'b1;
              state    <= ST_IDLE;
            end else if (!kind_off) begin
              out_st   <= {STAT_NOTE_ON, msg_st[3:0]};
              out_d1   <= note;
              out_d2   <= msg_d2;
              out_last <= 1'b0;
              kind_off <= 1'b1;
              state    <= ST_PL;
            end else begin
              out_st   <= {STAT_NOTE_OFF, msg_st[3:0]};
              out_d1   <= note;
              out_d2   <= 7'd0;
              out_last <= j == n_eff;
              kind_off <= 1'b0;
              if (j == n_eff) begin
                state <= ST_IDLE;
              end else begin
                s0    <= s1;
                j     <= j + 1'b1;
                state <= ST_SK;
              end
            end
          end
        end
        ST_TICKW: begin
          if (div_rsp.done) begin
            cur   <= div_rsp.rem[CUR_W-1:0];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid           = out_v;
  assign rsp.out_status      = out_st;
  assign rsp.out_data_first  = out_d1;
  assign rsp.out_data_second = out_d2;
  assign rsp.target_block    = out_tb;
  assign rsp.block_position  = out_pos;
  assign rsp.last_of_run     = out_last;

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_ready_no_div: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !div_rsp.busy)
    else $error("request taken while a division runs");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_SWAIT || state == ST_PLW1 ||
                      state == ST_PLW2 || state == ST_TICKW))
    else $error("division finished outside a wait state");

endmodule
`default_nettype wire
